@@ rtl/tbfc_pkg.sv @@
`timescale 1ns / 1ps

package tbfc_pkg;

  // default sizing
  localparam int RING_DEPTH_DEF  = 16;
  localparam int SAMPLE_BITS_DEF = 16;

  // register field widths
  localparam int TAPS_W      = 5;
  localparam int DELAY_W     = 4;
  localparam int COEF_W      = 18;
  localparam int COEF_FRAC   = 15;
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 18;

  // longest tap run per band
  localparam logic [TAPS_W-1:0] MAX_TAPS = TAPS_W'(16);

  // register reset values
  localparam logic [TAPS_W-1:0]         LOW_TAPS_RST   = TAPS_W'(10);
  localparam logic [TAPS_W-1:0]         MID_TAPS_RST   = TAPS_W'(5);
  localparam logic [TAPS_W-1:0]         HIGH_TAPS_RST  = TAPS_W'(1);
  localparam logic [DELAY_W-1:0]        MID_DELAY_RST  = DELAY_W'(3);
  localparam logic [DELAY_W-1:0]        HIGH_DELAY_RST = DELAY_W'(5);
  localparam logic signed [COEF_W-1:0]  LOW_COEF_RST   = COEF_W'(3277);
  localparam logic signed [COEF_W-1:0]  MID_COEF_RST   = COEF_W'(6554);
  localparam logic signed [COEF_W-1:0]  HIGH_COEF_RST  = COEF_W'(32768);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_LOW_TAPS   = 4'd0,
    REG_MID_TAPS   = 4'd1,
    REG_HIGH_TAPS  = 4'd2,
    REG_MID_DELAY  = 4'd3,
    REG_HIGH_DELAY = 4'd4,
    REG_LOW_COEF   = 4'd5,
    REG_MID_COEF   = 4'd6,
    REG_HIGH_COEF  = 4'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    BAND_LOW  = 2'd0,
    BAND_MID  = 2'd1,
    BAND_HIGH = 2'd2
  } band_t;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_SETUP = 2'd1,
    S_TAPS  = 2'd2,
    S_OUT   = 2'd3
  } seq_state_t;

  typedef struct packed {
    logic rd_en;
    logic acc_clear;
    logic res_we;
    logic out_load;
  } seq_ctl_t;

endpackage

@@ rtl/tbfc_ring.sv @@
`timescale 1ns / 1ps

module tbfc_ring #(
  parameter int DEPTH = tbfc_pkg::RING_DEPTH_DEF,
  parameter int DW    = tbfc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr_en,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  logic signed [DW-1:0]       wr_data,
  input  logic                       rd_en,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr,
  output logic                       rd_vld,
  output logic signed [DW-1:0]       rd_data
);
  import tbfc_pkg::*;

  logic signed [DW-1:0] mem [DEPTH];
  logic [DEPTH-1:0]     written;
  logic signed [DW-1:0] rd_q;
  logic                 rd_ok;

  // sample store, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // entries never written since reset read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      rd_vld  <= 1'b0;
      rd_ok   <= 1'b0;
    end else begin
      rd_vld <= rd_en;
      if (rd_en) begin
        rd_ok <= written[rd_addr];
      end
      if (wr_en) begin
        written[wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_data = rd_ok ? rd_q : '0;

endmodule

@@ rtl/tbfc_mac.sv @@
`timescale 1ns / 1ps

module tbfc_mac #(
  parameter int DW = tbfc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               acc_clear,
  input  logic signed [tbfc_pkg::COEF_W-1:0] coef,
  input  logic                               rd_vld,
  input  logic signed [DW-1:0]               rd_data,
  output logic                               busy,
  output logic signed [DW-1:0]               result
);
  import tbfc_pkg::*;

  localparam int PROD_W = DW + COEF_W;
  localparam int ACC_W  = PROD_W + 5;

  localparam logic signed [ACC_W-1:0] ROUND_HALF =
    {{(ACC_W-COEF_FRAC){1'b0}}, 1'b1, {(COEF_FRAC-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] SAT_HI = {{(ACC_W-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_LO = {{(ACC_W-DW+1){1'b1}}, {(DW-1){1'b0}}};

  logic signed [PROD_W-1:0] prod;
  logic                     prod_vld;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  rounded;
  logic signed [ACC_W-1:0]  scaled;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= rd_vld;
    end
  end

  // product register, then accumulate
  always_ff @(posedge clk) begin
    prod <= rd_data * coef;
    if (acc_clear) begin
      acc <= '0;
    end else if (prod_vld) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  // round half up, drop fraction, saturate
  always_comb begin
    rounded = acc + ROUND_HALF;
    scaled  = rounded >>> COEF_FRAC;
    if (scaled > SAT_HI) begin
      result = SAT_HI[DW-1:0];
    end else if (scaled < SAT_LO) begin
      result = SAT_LO[DW-1:0];
    end else begin
      result = scaled[DW-1:0];
    end
  end

  assign busy = rd_vld | prod_vld;

endmodule

@@ rtl/tbfc_seq.sv @@
`timescale 1ns / 1ps

module tbfc_seq #(
  parameter int DEPTH = tbfc_pkg::RING_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic [tbfc_pkg::TAPS_W-1:0]         low_taps,
  input  logic [tbfc_pkg::TAPS_W-1:0]         mid_taps,
  input  logic [tbfc_pkg::TAPS_W-1:0]         high_taps,
  input  logic [tbfc_pkg::DELAY_W-1:0]        mid_delay,
  input  logic [tbfc_pkg::DELAY_W-1:0]        high_delay,
  input  logic                                mac_busy,
  output logic                                in_stall,
  output logic [$clog2(DEPTH)-1:0]            wr_addr,
  output logic [$clog2(DEPTH)-1:0]            rd_addr,
  output tbfc_pkg::band_t                     band,
  output tbfc_pkg::seq_ctl_t                  ctl
);
  import tbfc_pkg::*;

  localparam int IDX_W   = $clog2(DEPTH);
  localparam int DELAY_N = 1 << DELAY_W;

  seq_state_t         state, state_next;
  band_t              band_next;
  logic [IDX_W-1:0]   wp, wp_next;
  logic [IDX_W-1:0]   cur, cur_next;
  logic [IDX_W-1:0]   idx, idx_next;
  logic [TAPS_W-1:0]  remain, remain_next;
  logic [IDX_W-1:0]   dmod_tab [DELAY_N];
  logic [DELAY_W-1:0] delay_sel;
  logic [TAPS_W-1:0]  taps_sel;
  logic [TAPS_W-1:0]  taps_clamped;
  logic [IDX_W-1:0]   dmod;
  logic [IDX_W-1:0]   start_idx;
  logic [IDX_W:0]     start_wrap;
  logic               accept;
  logic               band_done;

  // delay modulo depth, worked out at elaboration
  for (genvar g = 0; g < DELAY_N; g++) begin : g_dmod
    assign dmod_tab[g] = IDX_W'(g % DEPTH);
  end

  always_comb begin
    case (band)
      BAND_LOW: begin
        taps_sel  = low_taps;
        delay_sel = '0;
      end
      BAND_MID: begin
        taps_sel  = mid_taps;
        delay_sel = mid_delay;
      end
      BAND_HIGH: begin
        taps_sel  = high_taps;
        delay_sel = high_delay;
      end
      default: begin
        taps_sel  = '0;
        delay_sel = '0;
      end
    endcase
    taps_clamped = (taps_sel > MAX_TAPS) ? MAX_TAPS : taps_sel;
    dmod         = dmod_tab[delay_sel];
    start_wrap   = {1'b0, cur} + (IDX_W+1)'(DEPTH) - {1'b0, dmod};
    start_idx    = (cur >= dmod) ? (cur - dmod) : start_wrap[IDX_W-1:0];
  end

  assign accept    = in_valid && (state == S_IDLE);
  assign band_done = (state == S_TAPS) && (remain == '0) && !mac_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      band   <= BAND_LOW;
      wp     <= '0;
      cur    <= '0;
      idx    <= '0;
      remain <= '0;
    end else begin
      state  <= state_next;
      band   <= band_next;
      wp     <= wp_next;
      cur    <= cur_next;
      idx    <= idx_next;
      remain <= remain_next;
    end
  end

  always_comb begin
    state_next    = state;
    band_next     = band;
    wp_next       = wp;
    cur_next      = cur;
    idx_next      = idx;
    remain_next   = remain;
    ctl.rd_en     = 1'b0;
    ctl.acc_clear = 1'b0;
    ctl.res_we    = 1'b0;
    ctl.out_load  = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          cur_next   = wp;
          wp_next    = (wp == IDX_W'(DEPTH-1)) ? '0 : wp + 1'b1;
          band_next  = BAND_LOW;
          state_next = S_SETUP;
        end
      end
      S_SETUP: begin
        ctl.acc_clear = 1'b1;
        idx_next      = start_idx;
        remain_next   = taps_clamped;
        state_next    = S_TAPS;
      end
      S_TAPS: begin
        if (remain != '0) begin
          ctl.rd_en   = 1'b1;
          idx_next    = (idx == '0) ? IDX_W'(DEPTH-1) : idx - 1'b1;
          remain_next = remain - 1'b1;
        end else if (band_done) begin
          ctl.res_we = 1'b1;
          case (band)
            BAND_LOW: begin
              band_next  = BAND_MID;
              state_next = S_SETUP;
            end
            BAND_MID: begin
              band_next  = BAND_HIGH;
              state_next = S_SETUP;
            end
            default: begin
              state_next = S_OUT;
            end
          endcase
        end
      end
      S_OUT: begin
        if (!out_valid || !out_stall) begin
          ctl.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign in_stall = (state != S_IDLE);
  assign wr_addr  = wp;
  assign rd_addr  = idx;

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_SETUP) && (band == BAND_LOW))
    else $error("accepted transaction did not start the low band");

  a_high_ends_item: assert property (@(posedge clk) disable iff (rst)
    (band_done && (band == BAND_HIGH)) |=> (state == S_OUT))
    else $error("high band finished without moving to output");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    ctl.out_load |=> out_valid)
    else $error("result load did not raise output valid");

  a_remain_bounded: assert property (@(posedge clk) disable iff (rst)
    remain <= MAX_TAPS)
    else $error("tap counter beyond longest run");

endmodule

@@ rtl/three_band_fir_crossover.sv @@
// Three-band FIR crossover. Each input transaction writes one signed sample into a
// circular store of RING_DEPTH entries, then the low, mid and high bands each sum
// their tap count of stored samples, newest first, starting at the band's delay
// behind the new sample (the low band starts at the new sample itself), every tap
// scaled by the band's single Q3.15 coefficient. Sums are kept exact, rounded half
// up and saturated to SAMPLE_BITS. One result transaction carries all three bands.
// The store is a single-port-read memory walked by one shared multiply-accumulate
// unit, so the low, mid and high bands are worked one after another, each reading
// the band's clamped tap count of samples. The next input is taken once the
// previous result is in the output register, even if that result is still
// stalled. Store entries never written since reset read as zero, so no clearing
// pass is needed after reset. Tap counts above 16 act as 16, delays wrap modulo
// the store depth, and writes to register indexes beyond the list are ignored.
// Registers may be written only while no transaction is in flight.
`timescale 1ns / 1ps

module three_band_fir_crossover #(
  parameter int RING_DEPTH  = tbfc_pkg::RING_DEPTH_DEF,
  parameter int SAMPLE_BITS = tbfc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration write channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [tbfc_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [tbfc_pkg::CFG_DATA_W-1:0]      cfg_data,
  // sample input
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [SAMPLE_BITS-1:0]        in_sample,
  // band outputs
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [SAMPLE_BITS-1:0]        low_out,
  output logic signed [SAMPLE_BITS-1:0]        mid_out,
  output logic signed [SAMPLE_BITS-1:0]        high_out
);
  import tbfc_pkg::*;

  localparam int IDX_W = $clog2(RING_DEPTH);

  // configuration registers
  logic [TAPS_W-1:0]         low_taps, mid_taps, high_taps;
  logic [DELAY_W-1:0]        mid_delay, high_delay;
  logic signed [COEF_W-1:0]  low_coef, mid_coef, high_coef;

  // sequencer to datapath
  seq_ctl_t                  ctl;
  band_t                     band;
  logic [IDX_W-1:0]          wr_addr;
  logic [IDX_W-1:0]          rd_addr;
  logic                      accept;

  // store read side and the mac
  logic                      rd_vld;
  logic signed [SAMPLE_BITS-1:0] rd_data;
  logic signed [COEF_W-1:0]  coef_sel;
  logic                      mac_busy;
  logic signed [SAMPLE_BITS-1:0] band_result;

  // per-band results, held until the output register is free
  logic signed [SAMPLE_BITS-1:0] low_res, mid_res, high_res;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;

  // register writes, only the low bits of each field are kept
  always_ff @(posedge clk) begin
    if (rst) begin
      low_taps   <= LOW_TAPS_RST;
      mid_taps   <= MID_TAPS_RST;
      high_taps  <= HIGH_TAPS_RST;
      mid_delay  <= MID_DELAY_RST;
      high_delay <= HIGH_DELAY_RST;
      low_coef   <= LOW_COEF_RST;
      mid_coef   <= MID_COEF_RST;
      high_coef  <= HIGH_COEF_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_LOW_TAPS:   low_taps   <= cfg_data[TAPS_W-1:0];
        REG_MID_TAPS:   mid_taps   <= cfg_data[TAPS_W-1:0];
        REG_HIGH_TAPS:  high_taps  <= cfg_data[TAPS_W-1:0];
        REG_MID_DELAY:  mid_delay  <= cfg_data[DELAY_W-1:0];
        REG_HIGH_DELAY: high_delay <= cfg_data[DELAY_W-1:0];
        REG_LOW_COEF:   low_coef   <= cfg_data[COEF_W-1:0];
        REG_MID_COEF:   mid_coef   <= cfg_data[COEF_W-1:0];
        REG_HIGH_COEF:  high_coef  <= cfg_data[COEF_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // coefficient follows the band being walked, stable for the whole run
  always_comb begin
    case (band)
      BAND_LOW:  coef_sel = low_coef;
      BAND_MID:  coef_sel = mid_coef;
      BAND_HIGH: coef_sel = high_coef;
      default:   coef_sel = '0;
    endcase
  end

  tbfc_seq #(
    .DEPTH (RING_DEPTH)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .low_taps   (low_taps),
    .mid_taps   (mid_taps),
    .high_taps  (high_taps),
    .mid_delay  (mid_delay),
    .high_delay (high_delay),
    .mac_busy   (mac_busy),
    .in_stall   (in_stall),
    .wr_addr    (wr_addr),
    .rd_addr    (rd_addr),
    .band       (band),
    .ctl        (ctl)
  );

  // new sample goes in on the accepting edge, reads are issued after the setup state
  tbfc_ring #(
    .DEPTH (RING_DEPTH),
    .DW    (SAMPLE_BITS)
  ) u_ring (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (accept),
    .wr_addr (wr_addr),
    .wr_data (in_sample),
    .rd_en   (ctl.rd_en),
    .rd_addr (rd_addr),
    .rd_vld  (rd_vld),
    .rd_data (rd_data)
  );

  tbfc_mac #(
    .DW (SAMPLE_BITS)
  ) u_mac (
    .clk       (clk),
    .rst       (rst),
    .acc_clear (ctl.acc_clear),
    .coef      (coef_sel),
    .rd_vld    (rd_vld),
    .rd_data   (rd_data),
    .busy      (mac_busy),
    .result    (band_result)
  );

  // capture each band as its run drains
  always_ff @(posedge clk) begin
    if (ctl.res_we) begin
      case (band)
        BAND_LOW:  low_res  <= band_result;
        BAND_MID:  mid_res  <= band_result;
        BAND_HIGH: high_res <= band_result;
        default: begin
        end
      endcase
    end
  end

  // output register, parts the two handshakes
  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      low_out  <= low_res;
      mid_out  <= mid_res;
      high_out <= high_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

@@ bench/crossover_checker.sv @@
`timescale 1ns / 1ps

module crossover_checker
  import tbfc_pkg::*;
#(
  parameter int RING_DEPTH  = RING_DEPTH_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [CFG_INDEX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic signed [SAMPLE_BITS-1:0] low_out,
  input  logic signed [SAMPLE_BITS-1:0] mid_out,
  input  logic signed [SAMPLE_BITS-1:0] high_out,
  output int                            errors,
  output int                            waiting,
  output int                            results_seen
);

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] low;
    logic signed [SAMPLE_BITS-1:0] mid;
    logic signed [SAMPLE_BITS-1:0] high;
  } band_set_t;

  // model copy of the sample store and band settings
  logic signed [SAMPLE_BITS-1:0] ring [RING_DEPTH];
  int                            head;
  logic [TAPS_W-1:0]             taps_cfg  [3];
  logic [DELAY_W-1:0]            delay_cfg [3];
  logic signed [COEF_W-1:0]      coef_cfg  [3];
  band_set_t                     expected_bands [$];

  // exact sum, round half up, saturate
  function automatic logic signed [SAMPLE_BITS-1:0] band_output(input band_t b);
    longint acc;
    longint rounded;
    longint top;
    int     n;
    int     slot;
    acc = 0;
    n = (taps_cfg[b] > MAX_TAPS) ? int'(MAX_TAPS) : int'(taps_cfg[b]);
    slot = (head + RING_DEPTH - (int'(delay_cfg[b]) % RING_DEPTH)) % RING_DEPTH;
    for (int k = 0; k < n; k++) begin
      acc += longint'(ring[slot]) * longint'(coef_cfg[b]);
      slot = (slot == 0) ? RING_DEPTH - 1 : slot - 1;
    end
    rounded = (acc + (longint'(1) << (COEF_FRAC - 1))) >>> COEF_FRAC;
    top = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
    if (rounded > top) rounded = top;
    if (rounded < -top - 1) rounded = -top - 1;
    return rounded[SAMPLE_BITS-1:0];
  endfunction

  task automatic compare_band(input string label, input logic signed [SAMPLE_BITS-1:0] want,
                              input logic signed [SAMPLE_BITS-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, label, want, got);
    end
  endtask

  always @(posedge clk) begin
    band_set_t oldest;
    band_set_t fresh;
    if (rst) begin
      for (int i = 0; i < RING_DEPTH; i++) ring[i] = '0;
      head = 0;
      taps_cfg[BAND_LOW]   = LOW_TAPS_RST;
      taps_cfg[BAND_MID]   = MID_TAPS_RST;
      taps_cfg[BAND_HIGH]  = HIGH_TAPS_RST;
      delay_cfg[BAND_LOW]  = '0;
      delay_cfg[BAND_MID]  = MID_DELAY_RST;
      delay_cfg[BAND_HIGH] = HIGH_DELAY_RST;
      coef_cfg[BAND_LOW]   = LOW_COEF_RST;
      coef_cfg[BAND_MID]   = MID_COEF_RST;
      coef_cfg[BAND_HIGH]  = HIGH_COEF_RST;
      expected_bands.delete();
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_bands.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected, got low %0d mid %0d high %0d",
                   $time, low_out, mid_out, high_out);
        end else begin
          oldest = expected_bands.pop_front();
          compare_band("low_out", oldest.low, low_out);
          compare_band("mid_out", oldest.mid, mid_out);
          compare_band("high_out", oldest.high, high_out);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_LOW_TAPS:   taps_cfg[BAND_LOW]   = cfg_data[TAPS_W-1:0];
          REG_MID_TAPS:   taps_cfg[BAND_MID]   = cfg_data[TAPS_W-1:0];
          REG_HIGH_TAPS:  taps_cfg[BAND_HIGH]  = cfg_data[TAPS_W-1:0];
          REG_MID_DELAY:  delay_cfg[BAND_MID]  = cfg_data[DELAY_W-1:0];
          REG_HIGH_DELAY: delay_cfg[BAND_HIGH] = cfg_data[DELAY_W-1:0];
          REG_LOW_COEF:   coef_cfg[BAND_LOW]   = cfg_data[COEF_W-1:0];
          REG_MID_COEF:   coef_cfg[BAND_MID]   = cfg_data[COEF_W-1:0];
          REG_HIGH_COEF:  coef_cfg[BAND_HIGH]  = cfg_data[COEF_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        ring[head] = in_sample;
        fresh.low  = band_output(BAND_LOW);
        fresh.mid  = band_output(BAND_MID);
        fresh.high = band_output(BAND_HIGH);
        expected_bands.push_back(fresh);
        head = (head + 1) % RING_DEPTH;
      end
    end
    waiting = expected_bands.size();
  end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import tbfc_pkg::*;

  localparam int     SB              = SAMPLE_BITS_DEF;
  localparam int     CLK_PERIOD      = 20;
  localparam int     RANDOM_PHASES   = 16;
  localparam int     ITEMS_PER_PHASE = 100;
  localparam int     QUIET_PHASES    = 2;
  localparam int     DRAIN_LIMIT     = 20000;
  localparam int     TAIL_CYCLES     = 100;
  localparam longint TIMEOUT_NS      = 64'd20_000_000;

  // handy sample and coefficient extremes
  localparam logic signed [SB-1:0]     SAMPLE_MAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0]     SAMPLE_MIN = {1'b1, {(SB-1){1'b0}}};
  localparam logic [CFG_DATA_W-1:0]    COEF_MAX   = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic [CFG_DATA_W-1:0]    COEF_MIN   = {1'b1, {(COEF_W-1){1'b0}}};
  localparam int                       HALF_LSB   = 1 << (COEF_FRAC - 1);

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   in_valid;
  logic                   in_stall;
  logic signed [SB-1:0]   in_sample;
  logic                   out_valid;
  logic                   out_stall;
  logic signed [SB-1:0]   low_out;
  logic signed [SB-1:0]   mid_out;
  logic signed [SB-1:0]   high_out;

  int errors;
  int waiting;
  int results_seen;

  // idling controls, percent chance of an input gap before a transaction or of an output stall burst
  int gap_pct   = 0;
  int stall_pct = 0;

  int samples_sent  = 0;
  int reg_writes    = 0;
  int settings_used = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  three_band_fir_crossover u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_sample (in_sample),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .low_out   (low_out),
    .mid_out   (mid_out),
    .high_out  (high_out)
  );

  // watches both channels and the register port, predicts and compares
  crossover_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_sample    (in_sample),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .low_out      (low_out),
    .mid_out      (mid_out),
    .high_out     (high_out),
    .errors       (errors),
    .waiting      (waiting),
    .results_seen (results_seen)
  );

  // hard stop in case the handshake hangs
  initial begin
    #(TIMEOUT_NS);
    $display("%0t: timeout, %0d results still outstanding", $time, waiting);
    $display("Some tests failed");
    $finish;
  end

  // receiver back-pressure: random out_stall bursts
  initial begin : stall_gen
    int burst;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
        burst = $urandom_range(1, 14);
        out_stall <= 1'b1;
        repeat (burst) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // one register write; valid is left high so back-to-back writes need no dip
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    reg_writes++;
  endtask

  // full register set, optionally followed by a write to an unused index
  task automatic write_settings(input logic [CFG_DATA_W-1:0] lt, mt, ht, md, hd, lc, mc, hc,
                                input bit stray);
    write_reg(REG_LOW_TAPS, lt);
    write_reg(REG_MID_TAPS, mt);
    write_reg(REG_HIGH_TAPS, ht);
    write_reg(REG_MID_DELAY, md);
    write_reg(REG_HIGH_DELAY, hd);
    write_reg(REG_LOW_COEF, lc);
    write_reg(REG_MID_COEF, mc);
    write_reg(REG_HIGH_COEF, hc);
    if (stray)
      write_reg(CFG_INDEX_W'($urandom_range(int'(REG_HIGH_COEF) + 1, (1 << CFG_INDEX_W) - 1)),
                CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // hold the sender off until every predicted result has been taken
  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (waiting != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // one input transaction, with a possible idle burst in front of it
  task automatic send_sample(input logic signed [SB-1:0] value);
    int gap;
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 14);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    samples_sent++;
  endtask

  function automatic logic signed [SB-1:0] random_sample();
    case ($urandom_range(0, 9))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2:       return SB'($urandom_range(0, 255)) - SB'(128);
      default: return SB'($urandom);
    endcase
  endfunction

  // tap count in the low bits, random junk above it now and then
  function automatic logic [CFG_DATA_W-1:0] random_taps();
    logic [CFG_DATA_W-1:0] d;
    d = CFG_DATA_W'($urandom);
    case ($urandom_range(0, 9))
      0:       d[TAPS_W-1:0] = '0;
      1:       d[TAPS_W-1:0] = TAPS_W'($urandom_range(17, 31));
      2:       d[TAPS_W-1:0] = MAX_TAPS;
      default: d[TAPS_W-1:0] = TAPS_W'($urandom_range(1, 16));
    endcase
    if ($urandom_range(0, 1)) d[CFG_DATA_W-1:TAPS_W] = '0;
    return d;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_coef();
    case ($urandom_range(0, 7))
      0:       return COEF_MAX;
      1:       return COEF_MIN;
      2:       return CFG_DATA_W'($urandom_range(0, 3)) - CFG_DATA_W'(1);
      default: return CFG_DATA_W'($urandom);
    endcase
  endfunction

  initial begin : stimulus
    int guard;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    in_sample <= '0;
    rst       <= 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset settings: full-scale steps both ways through the default bands
    gap_pct   = 20;
    stall_pct = 20;
    repeat (3) send_sample(SAMPLE_MAX);
    repeat (3) send_sample(SAMPLE_MIN);

    // extremes: longest runs, widest mid delay, largest gains of both signs
    drain_results();
    write_settings(CFG_DATA_W'(MAX_TAPS), CFG_DATA_W'(MAX_TAPS), CFG_DATA_W'(MAX_TAPS),
                   CFG_DATA_W'({DELAY_W{1'b1}}), '0, COEF_MAX, COEF_MIN, CFG_DATA_W'(1), 1'b0);
    repeat (3) send_sample(SAMPLE_MAX);
    repeat (3) send_sample(SAMPLE_MIN);

    // corner cases: low band with no taps (junk above the field), mid run past
    // the limit, high band a single unit tap for the rounding ties, plus a
    // write to an index past the register list
    drain_results();
    write_settings({{(CFG_DATA_W-TAPS_W){1'b1}}, {TAPS_W{1'b0}}},
                   CFG_DATA_W'({TAPS_W{1'b1}}), CFG_DATA_W'(1),
                   {{(CFG_DATA_W-DELAY_W){1'b1}}, {DELAY_W{1'b0}}}, '0,
                   COEF_MAX, {CFG_DATA_W{1'b1}}, CFG_DATA_W'(1), 1'b1);
    send_sample(SB'(HALF_LSB));
    send_sample(SB'(-HALF_LSB));
    send_sample(SB'(HALF_LSB - 1));
    send_sample(SB'(-HALF_LSB - 1));
    send_sample('0);
    send_sample(SAMPLE_MAX);

    // random settings per phase, random samples, varying idle pressure
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain_results();
      if (p >= RANDOM_PHASES - QUIET_PHASES) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        gap_pct   = 15 * $urandom_range(0, 4);
        stall_pct = 15 * $urandom_range(0, 4);
      end
      write_settings(random_taps(), random_taps(), random_taps(),
                     CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                     random_coef(), random_coef(), random_coef(),
                     $urandom_range(0, 2) == 0);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        // now and then let the pipe run completely dry mid-phase
        if (p < RANDOM_PHASES - QUIET_PHASES && $urandom_range(0, 99) == 0) drain_results();
        send_sample(random_sample());
      end
    end

    // wind down: no more input, no more stalls, wait for the stragglers
    in_valid <= 1'b0;
    stall_pct = 0;
    guard = 0;
    @(negedge clk);
    while (waiting != 0 && guard < DRAIN_LIMIT) begin
      @(negedge clk);
      guard++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    @(negedge clk);

    if (waiting != 0)
      $display("%0t: %0d expected results never arrived", $time, waiting);
    $display("covered %0d samples under %0d register settings, %0d register writes",
             samples_sent, settings_used, reg_writes);
    $display("%0d band result transactions compared, %0d mismatches", results_seen, errors);
    if (errors == 0 && waiting == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/tbfc_pkg.sv
rtl/tbfc_ring.sv
rtl/tbfc_mac.sv
rtl/tbfc_seq.sv
rtl/three_band_fir_crossover.sv
bench/crossover_checker.sv
bench/testbench.sv
